@@ rtl/ellrast_pkg.sv @@
// Shared types, widths and command codes of the midpoint ellipse rasterizer.
package ellrast_pkg;

    localparam int COORD_W = 11;
    localparam int RAD_W   = 10;
    localparam int POINT_W = 12;
    localparam int POSX_W  = 11;
    localparam int POSY_W  = 12;
    localparam int SQ_W    = 20;
    localparam int SLOPE_W = 32;
    localparam int DEC_W   = 48;
    localparam int MUL_W   = 24;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int IDX_W   = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REGION1,
        PH_REGION2,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RY,
        S_RXRY,
        S_INIT,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SW4,
        S_SW5,
        S_SW6,
        S_STEPA,
        S_STEPB,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_RYRY,
        OP_MUL_RX2RY,
        OP_INIT,
        OP_SW_TX,
        OP_SW_RYTX,
        OP_SW_TY,
        OP_SW_RXTY,
        OP_SW_RXRY,
        OP_SW_DEC,
        OP_STEP_R1,
        OP_STEP_R2,
        OP_STEP_DEC
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] emit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic slope_lt;
        logic pos_y_neg;
        logic pos_y_zero;
    } t_dp_status;

endpackage

@@ rtl/ellrast_if.sv @@
// Valid/ready channel interfaces for start/advance items and plotted points.
interface ellrast_in_if import ellrast_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic        [RAD_W-1:0]    radius_x;
    logic        [RAD_W-1:0]    radius_y;

    modport source (output valid, kind, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink (input valid, kind, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface ellrast_out_if import ellrast_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [POINT_W-1:0]  point_x;
    logic signed [POINT_W-1:0]  point_y;
    logic                       step_last;
    logic                       shape_done;

    modport source (output valid, point_x, point_y, step_last, shape_done,
                    input ready);
    modport sink (input valid, point_x, point_y, step_last, shape_done,
                  output ready);
endinterface

@@ rtl/ellrast_dp.sv @@
// Datapath: shared multiplier, decision and slope registers, point generation.
module ellrast_dp import ellrast_pkg::*; (
    input  logic                       i_clk,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic        [RAD_W-1:0]    i_radius_x,
    input  logic        [RAD_W-1:0]    i_radius_y,
    output t_dp_status                 o_status,
    output logic signed [POINT_W-1:0]  o_point_x,
    output logic signed [POINT_W-1:0]  o_point_y,
    output logic                       o_step_last,
    output logic                       o_shape_done
);

    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic        [RAD_W-1:0]   r_rad_y;
    logic        [SQ_W-1:0]    r_rx2;
    logic        [SQ_W-1:0]    r_ry2;
    logic        [POSX_W-1:0]  r_pos_x;
    logic signed [POSY_W-1:0]  r_pos_y;
    logic signed [SLOPE_W-1:0] r_slope_x;
    logic signed [SLOPE_W-1:0] r_slope_y;
    logic signed [DEC_W-1:0]   r_decision;
    logic        [PROD_W-1:0]  r_prod;
    logic signed [DEC_W-1:0]   r_acc;
    logic        [POSX_W-1:0]  r_out_x;
    logic signed [POSY_W-1:0]  r_out_y;
    logic                      r_out_done;
    logic                      r_use_sx;
    logic                      r_use_sy;
    logic                      r_step_r1;

    logic        [MUL_W-1:0]   mul_a;
    logic        [MUL_W-1:0]   mul_b;
    logic        [PROD_W-1:0]  mul_p;
    logic        [POSY_W-1:0]  tx;
    logic signed [POSY_W-1:0]  ty;
    logic        [POSY_W-1:0]  ty_abs;
    logic signed [SLOPE_W-1:0] ry2_x2;
    logic signed [SLOPE_W-1:0] rx2_x2;
    logic signed [DEC_W-1:0]   prod_x4;
    logic signed [DEC_W-1:0]   init_dec;
    logic signed [DEC_W-1:0]   sx_x4;
    logic signed [DEC_W-1:0]   sy_x4;
    logic signed [DEC_W-1:0]   sq_x4;
    logic signed [DEC_W-1:0]   step_dec;
    logic                      dec_neg;
    logic                      dec_pos;
    logic signed [POINT_W-1:0] off_x;
    logic signed [POINT_W-1:0] off_y;
    logic signed [POINT_W-1:0] base_x;
    logic signed [POINT_W-1:0] base_y;

    assign tx      = {r_pos_x, 1'b1};
    assign ty      = r_pos_y - 12'sd1;
    assign ty_abs  = ty[POSY_W-1] ? 12'(-ty) : 12'(ty);
    assign ry2_x2  = $signed({11'd0, r_ry2, 1'b0});
    assign rx2_x2  = $signed({11'd0, r_rx2, 1'b0});
    assign prod_x4 = $signed({r_prod[PROD_W-3:0], 2'b00});
    assign init_dec = $signed({26'd0, r_ry2, 2'b00}) - prod_x4 + $signed({28'd0, r_rx2});
    assign sx_x4   = {{14{r_slope_x[SLOPE_W-1]}}, r_slope_x, 2'b00};
    assign sy_x4   = {{14{r_slope_y[SLOPE_W-1]}}, r_slope_y, 2'b00};
    assign sq_x4   = r_step_r1 ? $signed({26'd0, r_ry2, 2'b00})
                               : $signed({26'd0, r_rx2, 2'b00});
    assign step_dec = r_decision + (r_use_sx ? sx_x4 : 48'sd0)
                      - (r_use_sy ? sy_x4 : 48'sd0) + sq_x4;
    assign dec_neg = r_decision[DEC_W-1];
    assign dec_pos = !dec_neg && (r_decision != 48'sd0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                mul_a = {14'd0, i_radius_x};
                mul_b = {14'd0, i_radius_x};
            end
            OP_MUL_RYRY: begin
                mul_a = {14'd0, r_rad_y};
                mul_b = {14'd0, r_rad_y};
            end
            OP_MUL_RX2RY: begin
                mul_a = {4'd0, r_rx2};
                mul_b = {14'd0, r_rad_y};
            end
            OP_SW_TX: begin
                mul_a = {12'd0, tx};
                mul_b = {12'd0, tx};
            end
            OP_SW_RYTX: begin
                mul_a = {4'd0, r_ry2};
                mul_b = r_prod[MUL_W-1:0];
            end
            OP_SW_TY: begin
                mul_a = {12'd0, ty_abs};
                mul_b = {12'd0, ty_abs};
            end
            OP_SW_RXTY: begin
                mul_a = {4'd0, r_rx2};
                mul_b = r_prod[MUL_W-1:0];
            end
            OP_SW_RXRY: begin
                mul_a = {4'd0, r_rx2};
                mul_b = {4'd0, r_ry2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cx      <= i_center_x;
                r_cy      <= i_center_y;
                r_rad_y   <= i_radius_y;
                r_pos_x   <= '0;
                r_pos_y   <= $signed({2'b00, i_radius_y});
                r_slope_x <= '0;
                r_prod    <= mul_p;
            end
            OP_MUL_RYRY: begin
                r_rx2  <= r_prod[SQ_W-1:0];
                r_prod <= mul_p;
            end
            OP_MUL_RX2RY: begin
                r_ry2  <= r_prod[SQ_W-1:0];
                r_prod <= mul_p;
            end
            OP_INIT: begin
                r_slope_y  <= $signed({r_prod[SLOPE_W-2:0], 1'b0});
                r_decision <= init_dec;
            end
            OP_SW_TX, OP_SW_RYTX, OP_SW_RXTY: begin
                r_prod <= mul_p;
            end
            OP_SW_TY: begin
                r_acc  <= $signed(r_prod);
                r_prod <= mul_p;
            end
            OP_SW_RXRY: begin
                r_acc  <= r_acc + prod_x4;
                r_prod <= mul_p;
            end
            OP_SW_DEC: begin
                r_decision <= r_acc - prod_x4;
            end
            OP_STEP_R1: begin
                r_out_x    <= r_pos_x;
                r_out_y    <= r_pos_y;
                r_out_done <= 1'b0;
                r_step_r1  <= 1'b1;
                r_pos_x    <= r_pos_x + 11'd1;
                r_slope_x  <= r_slope_x + ry2_x2;
                r_use_sx   <= 1'b1;
                r_use_sy   <= !dec_neg;
                if (!dec_neg) begin
                    r_pos_y   <= r_pos_y - 12'sd1;
                    r_slope_y <= r_slope_y - rx2_x2;
                end
            end
            OP_STEP_R2: begin
                r_out_x    <= r_pos_x;
                r_out_y    <= r_pos_y;
                r_out_done <= (r_pos_y == 12'sd0);
                r_step_r1  <= 1'b0;
                r_pos_y    <= r_pos_y - 12'sd1;
                r_slope_y  <= r_slope_y - rx2_x2;
                r_use_sx   <= !dec_pos;
                r_use_sy   <= 1'b1;
                if (!dec_pos) begin
                    r_pos_x   <= r_pos_x + 11'd1;
                    r_slope_x <= r_slope_x + ry2_x2;
                end
            end
            OP_STEP_DEC: begin
                r_decision <= step_dec;
            end
            default: begin
            end
        endcase
    end

    assign o_status.slope_lt   = (r_slope_x < r_slope_y);
    assign o_status.pos_y_neg  = r_pos_y[POSY_W-1];
    assign o_status.pos_y_zero = (r_pos_y == 12'sd0);

    assign base_x = {r_cx[COORD_W-1], r_cx};
    assign base_y = {r_cy[COORD_W-1], r_cy};
    assign off_x  = $signed({1'b0, r_out_x});
    assign off_y  = r_out_y;

    assign o_point_x    = i_cmd.emit_idx[0] ? (base_x - off_x) : (base_x + off_x);
    assign o_point_y    = i_cmd.emit_idx[1] ? (base_y - off_y) : (base_y + off_y);
    assign o_step_last  = (i_cmd.emit_idx == 2'd3);
    assign o_shape_done = r_out_done;

endmodule

@@ rtl/ellrast_ctrl.sv @@
// Controller: sequences start, region switch, plotting step and point emission.
module ellrast_ctrl import ellrast_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state;
    t_state           n_state;
    t_phase           r_phase;
    t_phase           n_phase;
    logic [IDX_W-1:0] r_emit_idx;
    logic [IDX_W-1:0] n_emit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_emit_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_emit_idx <= n_emit_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_emit_idx = r_emit_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_kind) begin
                        n_state = S_SQ_RY;
                        n_phase = PH_REGION1;
                    end else if (r_phase == PH_REGION1 && !i_status.slope_lt) begin
                        n_state = S_SW1;
                    end else if (r_phase == PH_REGION1 || r_phase == PH_REGION2) begin
                        n_state = S_STEPA;
                    end
                end
            end
            S_SQ_RY: n_state = S_RXRY;
            S_RXRY:  n_state = S_INIT;
            S_INIT:  n_state = S_IDLE;
            S_SW1:   n_state = S_SW2;
            S_SW2:   n_state = S_SW3;
            S_SW3:   n_state = S_SW4;
            S_SW4:   n_state = S_SW5;
            S_SW5:   n_state = S_SW6;
            S_SW6: begin
                n_state = S_STEPA;
                n_phase = PH_REGION2;
            end
            S_STEPA: begin
                if (r_phase == PH_REGION2 && i_status.pos_y_neg) begin
                    n_state = S_IDLE;
                    n_phase = PH_DONE;
                end else begin
                    n_state    = S_STEPB;
                    n_emit_idx = '0;
                    if (r_phase == PH_REGION2 && i_status.pos_y_zero) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            S_STEPB: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_ready) begin
                    n_emit_idx = r_emit_idx + 2'd1;
                    if (r_emit_idx == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.emit_idx  = r_emit_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_in_kind) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_SQ_RY: o_cmd.op = OP_MUL_RYRY;
            S_RXRY:  o_cmd.op = OP_MUL_RX2RY;
            S_INIT:  o_cmd.op = OP_INIT;
            S_SW1:   o_cmd.op = OP_SW_TX;
            S_SW2:   o_cmd.op = OP_SW_RYTX;
            S_SW3:   o_cmd.op = OP_SW_TY;
            S_SW4:   o_cmd.op = OP_SW_RXTY;
            S_SW5:   o_cmd.op = OP_SW_RXRY;
            S_SW6:   o_cmd.op = OP_SW_DEC;
            S_STEPA: begin
                if (r_phase == PH_REGION1) begin
                    o_cmd.op = OP_STEP_R1;
                end else if (r_phase == PH_REGION2 && !i_status.pos_y_neg) begin
                    o_cmd.op = OP_STEP_R2;
                end
            end
            S_STEPB: o_cmd.op = OP_STEP_DEC;
            S_EMIT:  o_out_valid = 1'b1;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_IDLE && r_state == S_IDLE))
        else $error("controller not idle after reset");

    a_switch_region2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW6) |=> (r_phase == PH_REGION2 && r_state == S_STEPA))
        else $error("region switch did not enter region 2");

    a_emit_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEPB) |=> (r_state == S_EMIT && r_emit_idx == 2'd0))
        else $error("point emission did not start at the first point");

    a_last_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_emit_idx == 2'd3 && i_out_ready) |=> (r_state == S_IDLE))
        else $error("step did not end after its fourth beat");

endmodule

@@ rtl/ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
//
// Input channel i_item carries one beat per command. kind = 0 starts a new
// ellipse from center_x, center_y, radius_x and radius_y; kind = 1 advances
// one plotting step. Output channel o_point carries plotted pixels.
// A start beat gives no output and keeps the block busy through S_SQ_RY,
// S_RXRY and S_INIT while the shared 24x24 multiplier forms the squared
// radii and initial terms. An advance gives four point beats, one per cycle
// while the receiver is ready, in the order (+x,+y), (-x,+y), (+x,-y),
// (-x,-y); step_last marks the fourth and shape_done marks all four of the
// final step. An accepted advance passes through S_STEPA and S_STEPB before
// the first point beat, and the single step where region 1 switches to
// region 2 first passes through S_SW1 to S_SW6. An advance before any
// start or after the shape is finished produces no beats.
// Items are handled one at a time: i_item.ready is high only while idle.
// When the receiver stalls, the current point is held and the block waits.
// A synchronous reset returns the block to idle with no shape loaded.
module ellipse_rasterizer import ellrast_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ellrast_in_if.sink    i_item,
    ellrast_out_if.source o_point
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ellrast_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_kind   (i_item.kind),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_point.valid),
        .i_out_ready (o_point.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ellrast_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_center_x   (i_item.center_x),
        .i_center_y   (i_item.center_y),
        .i_radius_x   (i_item.radius_x),
        .i_radius_y   (i_item.radius_y),
        .o_status     (status),
        .o_point_x    (o_point.point_x),
        .o_point_y    (o_point.point_y),
        .o_step_last  (o_point.step_last),
        .o_shape_done (o_point.shape_done)
    );

endmodule
